// File: rtl/tsac_pkg.sv
// Shared types, widths and constants of the touch sample averaging and calibration block.
package tsac_pkg;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Sample and result fields.
    localparam int WORD_W      = 16;
    localparam int FRAME_SHIFT = 3;
    localparam int RAW_W       = WORD_W - FRAME_SHIFT;
    localparam int OUT_W       = 16;

    // Register widths.
    localparam int THR_W  = 13;
    localparam int SIZE_W = 12;
    localparam int OFS_W  = 13;
    localparam int STR_W  = 16;
    localparam int ORI_W  = 2;

    // Group accumulation.
    localparam int SUM_W = 18;
    localparam int CNT_W = 5;

    // Constant divider: the raw full scale fits in the raw field width.
    localparam int DIV_W = RAW_W;

    // Scaling arithmetic. An average and an offset are both raw values, so the
    // offset distance never needs more than the raw width.
    localparam int Q14_SHIFT = 14;
    localparam int DIFF_W    = SUM_W + 1;
    localparam int MAG_W     = RAW_W;
    localparam int PROD1_W   = MAG_W + STR_W;
    localparam int PROD_W    = PROD1_W + SIZE_W;
    localparam int QUO_W     = PROD_W - Q14_SHIFT;
    localparam int SCL_W     = QUO_W + 2;

    localparam logic signed [SCL_W-1:0] SAT_MAX = SCL_W'(32767);
    localparam logic signed [SCL_W-1:0] SAT_MIN = -SCL_W'(32768);

    // Parameter defaults.
    localparam int SAMPLES_PER_GROUP_DEF = 8;
    localparam int RAW_FULL_SCALE_DEF    = 4095;

    // Register reset values.
    localparam logic [THR_W-1:0]  THR_RST    = '0;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(240);
    localparam logic [OFS_W-1:0]  OFS_RST    = '0;
    localparam logic [STR_W-1:0]  STR_RST    = STR_W'(16384);

    typedef enum logic [2:0] {
        REG_THRESH   = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_HEIGHT   = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_STRETCH_X = 3'd5,
        REG_STRETCH_Y = 3'd6,
        REG_ORIENT   = 3'd7
    } t_reg_idx;

    typedef enum logic [ORI_W-1:0] {
        ORIENT_NONE    = 2'd0,
        ORIENT_MIRROR  = 2'd1,
        ORIENT_SWAP_MX = 2'd2,
        ORIENT_SWAP_MY = 2'd3
    } t_orient;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
        logic [OFS_W-1:0]  offset_x;
        logic [OFS_W-1:0]  offset_y;
        logic [STR_W-1:0]  stretch_x;
        logic [STR_W-1:0]  stretch_y;
        t_orient           orientation;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_DIV_AVG,
        OP_CAP_AVG,
        OP_DIFF,
        OP_MUL_STR,
        OP_MUL_SIZE,
        OP_DIV_SCL,
        OP_CAP_SCL,
        OP_LOAD_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        SEL_P,
        SEL_X,
        SEL_Y
    } t_sel;

    typedef struct packed {
        t_dp_op op;
        t_sel   sel;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic reject;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_CHECK,
        ST_DIFF,
        ST_MUL_STR,
        ST_MUL_SIZE,
        ST_SCL_GO,
        ST_SCL_WAIT,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/tsac_if.sv
// Handshake channel interfaces for touch samples and calibrated results.
interface tsac_smp_if import tsac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pressure_word;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
    logic              bus_error;

    modport source (output valid, pressure_word, x_word, y_word, bus_error, input ready);
    modport sink   (input valid, pressure_word, x_word, y_word, bus_error, output ready);
endinterface

interface tsac_res_if import tsac_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    touched;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;

    modport source (output valid, touched, screen_x, screen_y, input ready);
    modport sink   (input valid, touched, screen_x, screen_y, output ready);
endinterface

// File: rtl/touch_sample_average_calibrate_top.sv
// Top level of the touch sample averaging and calibration block.
//
// The block takes touch-controller samples (pressure, x and y frame words plus a
// bus-error flag) one beat at a time, sums SAMPLES_PER_GROUP of them and, at the
// end of each group, delivers one result beat: not touched with zero coordinates
// if any sample of the group had a bus error or the averaged pressure is below the
// threshold, otherwise the offset-corrected, stretched, screen-scaled, oriented and
// saturated position. A sample that does not close a group is taken with no stall.
// The sample that closes a group is followed by group-end work (shorter for a
// rejected group) during which no sample is accepted. Each of the three averages
// passes through the shared constant divider (start, reciprocal multiply, capture),
// a check state tests the group, each axis takes an offset distance, two registered
// multiplies and a division by full scale, and a last state loads the result. The
// result sits in an output register, so the next group's samples are taken while it
// waits; only the end of the next group waits for the result to be taken, and that
// wait adds to the group-end work.
// Configuration is through an APB port with register i at byte address 4*i; writes
// are expected only while the block is idle.
module touch_sample_average_calibrate_top import tsac_pkg::*; #(
    parameter int SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
    parameter int RAW_FULL_SCALE    = RAW_FULL_SCALE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tsac_smp_if.sink          i_smp,
    tsac_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_smp.ready = in_ready;

    // Register file; values are held as masked to each register's width.
    tsac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller accepts samples only in its idle state and walks the
    // group-end sequence with at most one datapath operation per state.
    tsac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the group sums, the shared divider, the scaling
    // multipliers and the result register that drives the output channel.
    tsac_dp #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
        .RAW_FULL_SCALE    (RAW_FULL_SCALE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_cfg           (cfg),
        .i_pressure_word (i_smp.pressure_word),
        .i_x_word        (i_smp.x_word),
        .i_y_word        (i_smp.y_word),
        .i_bus_error     (i_smp.bus_error),
        .i_out_ready     (o_res.ready),
        .o_sts           (dp_sts),
        .o_out_valid     (o_res.valid),
        .o_touched       (o_res.touched),
        .o_screen_x      (o_res.screen_x),
        .o_screen_y      (o_res.screen_y)
    );

`ifndef SYNTHESIS
    // A rejected group always reports the origin.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.touched) |-> (o_res.screen_x == '0 && o_res.screen_y == '0))
        else $error("not-touched result carries nonzero coordinates");

    // The sums only move on an accepted sample beat.
    a_acc_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_ACC) |-> (i_smp.valid && i_smp.ready))
        else $error("accumulation without an accepted sample beat");

    // A sample inside a group never stalls the next one.
    a_mid_group_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready && !dp_sts.last) |=> i_smp.ready)
        else $error("input stalled after a sample that did not close a group");

    // Loading a result always presents it on the output channel.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_LOAD_OUT) |=> o_res.valid)
        else $error("loaded result not presented on the output channel");
`endif

endmodule

// File: rtl/tsac_regs.sv
// APB configuration register file.
module tsac_regs import tsac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= THR_RST;
            r_cfg.screen_width  <= WIDTH_RST;
            r_cfg.screen_height <= HEIGHT_RST;
            r_cfg.offset_x      <= OFS_RST;
            r_cfg.offset_y      <= OFS_RST;
            r_cfg.stretch_x     <= STR_RST;
            r_cfg.stretch_y     <= STR_RST;
            r_cfg.orientation   <= ORIENT_NONE;
        end else if (wr_en) begin
            case (idx)
                REG_THRESH:    r_cfg.threshold     <= pwdata[THR_W-1:0];
                REG_WIDTH:     r_cfg.screen_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:    r_cfg.screen_height <= pwdata[SIZE_W-1:0];
                REG_OFFSET_X:  r_cfg.offset_x      <= pwdata[OFS_W-1:0];
                REG_OFFSET_Y:  r_cfg.offset_y      <= pwdata[OFS_W-1:0];
                REG_STRETCH_X: r_cfg.stretch_x     <= pwdata[STR_W-1:0];
                REG_STRETCH_Y: r_cfg.stretch_y     <= pwdata[STR_W-1:0];
                REG_ORIENT:    r_cfg.orientation   <= t_orient'(pwdata[ORI_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THRESH:    prdata = DATA_W'(r_cfg.threshold);
            REG_WIDTH:     prdata = DATA_W'(r_cfg.screen_width);
            REG_HEIGHT:    prdata = DATA_W'(r_cfg.screen_height);
            REG_OFFSET_X:  prdata = DATA_W'(r_cfg.offset_x);
            REG_OFFSET_Y:  prdata = DATA_W'(r_cfg.offset_y);
            REG_STRETCH_X: prdata = DATA_W'(r_cfg.stretch_x);
            REG_STRETCH_Y: prdata = DATA_W'(r_cfg.stretch_y);
            REG_ORIENT:    prdata = DATA_W'(r_cfg.orientation);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/tsac_div.sv
// Constant divider for the group size and the raw full scale, by reciprocal multiplication.
module tsac_div import tsac_pkg::*; #(
    parameter int SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
    parameter int RAW_FULL_SCALE    = RAW_FULL_SCALE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_scale,
    input  logic [QUO_W-1:0] i_dividend,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_done
);

    // A reciprocal rounded up, with a shift of the dividend width plus the divisor
    // width, gives the exact floor for every dividend of that width. The full scale
    // is at least 255, so its reciprocal needs seven bits fewer than its shift.
    localparam int AVG_K = SUM_W + CNT_W;
    localparam int SCL_K = QUO_W + DIV_W;
    localparam int RCP_W = SCL_K - 7;
    localparam int PRD_W = QUO_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_K) + 64'(SAMPLES_PER_GROUP) - 64'd1) / 64'(SAMPLES_PER_GROUP));
    localparam logic [RCP_W-1:0] SCL_RCP =
        RCP_W'(((64'd1 << SCL_K) + 64'(RAW_FULL_SCALE) - 64'd1) / 64'(RAW_FULL_SCALE));

    logic             r_busy;
    logic             r_done;
    logic             r_scl;
    logic [QUO_W-1:0] r_num;
    logic [PRD_W-1:0] r_prod;
    logic [RCP_W-1:0] rcp;

    assign rcp    = r_scl ? SCL_RCP : AVG_RCP;
    assign o_quo  = r_scl ? QUO_W'(r_prod >> SCL_K) : QUO_W'(r_prod >> AVG_K);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // The operands are a quotient-wide dividend and a reciprocal-wide constant.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_scl <= i_scale;
        end
        if (r_busy) begin
            r_prod <= PRD_W'(r_num) * PRD_W'(rcp);
        end
    end

endmodule

// File: rtl/tsac_dp.sv
// Datapath: group sums, averages, scaling multiplies, orientation and result register.
module tsac_dp import tsac_pkg::*; #(
    parameter int SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
    parameter int RAW_FULL_SCALE    = RAW_FULL_SCALE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  t_cfg                    i_cfg,
    input  logic [WORD_W-1:0]       i_pressure_word,
    input  logic [WORD_W-1:0]       i_x_word,
    input  logic [WORD_W-1:0]       i_y_word,
    input  logic                    i_bus_error,
    input  logic                    i_out_ready,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic                    o_touched,
    output logic signed [OUT_W-1:0] o_screen_x,
    output logic signed [OUT_W-1:0] o_screen_y
);

    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_psum, r_xsum, r_ysum;
    logic               r_err;
    logic [SUM_W-1:0]   r_pavg, r_xavg, r_yavg;
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;
    logic [PROD1_W-1:0] r_prod1;
    logic [PROD_W-1:0]  r_prod;
    logic signed [SCL_W-1:0] r_sx, r_sy;
    logic               r_out_valid;
    logic               r_touched;
    logic signed [OUT_W-1:0] r_screen_x, r_screen_y;

    logic               div_start;
    logic               div_scale;
    logic [QUO_W-1:0]   div_dividend;
    logic [QUO_W-1:0]   div_quo;
    logic               div_done;

    logic [SUM_W-1:0]   sum_sel;
    logic [SUM_W-1:0]   avg_sel;
    logic [OFS_W-1:0]   ofs_sel;
    logic [STR_W-1:0]   str_sel;
    logic [SIZE_W-1:0]  size_sel;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]  diff_abs;
    logic signed [SCL_W-1:0]  scl_mag;
    logic signed [SCL_W-1:0]  w_s, h_s, ox, oy;
    logic               reject;

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SCL_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    tsac_div #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
        .RAW_FULL_SCALE    (RAW_FULL_SCALE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_scale    (div_scale),
        .i_dividend (div_dividend),
        .o_quo      (div_quo),
        .o_done     (div_done)
    );

    // Operand selection.
    always_comb begin
        case (i_cmd.sel)
            SEL_P:   sum_sel = r_psum;
            SEL_X:   sum_sel = r_xsum;
            default: sum_sel = r_ysum;
        endcase
        if (i_cmd.sel == SEL_X) begin
            avg_sel  = r_xavg;
            ofs_sel  = i_cfg.offset_x;
            str_sel  = i_cfg.stretch_x;
            size_sel = i_cfg.screen_width;
        end else begin
            avg_sel  = r_yavg;
            ofs_sel  = i_cfg.offset_y;
            str_sel  = i_cfg.stretch_y;
            size_sel = i_cfg.screen_height;
        end
    end

    assign div_start = (i_cmd.op == OP_DIV_AVG) || (i_cmd.op == OP_DIV_SCL);
    assign div_scale = (i_cmd.op == OP_DIV_SCL);

    // The Q2.14 scale is dropped before dividing by full scale; nested floors keep it exact.
    always_comb begin
        if (i_cmd.op == OP_DIV_SCL) begin
            div_dividend = r_prod[PROD_W-1:Q14_SHIFT];
        end else begin
            div_dividend = QUO_W'(sum_sel);
        end
    end

    assign diff     = $signed({1'b0, avg_sel}) - $signed(DIFF_W'(ofs_sel));
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign scl_mag  = $signed(SCL_W'(div_quo));

    assign w_s = $signed(SCL_W'(i_cfg.screen_width));
    assign h_s = $signed(SCL_W'(i_cfg.screen_height));

    always_comb begin
        case (i_cfg.orientation)
            ORIENT_NONE: begin
                ox = r_sx;
                oy = r_sy;
            end
            ORIENT_MIRROR: begin
                ox = w_s - r_sx;
                oy = h_s - r_sy;
            end
            ORIENT_SWAP_MX: begin
                ox = r_sy;
                oy = w_s - r_sx;
            end
            ORIENT_SWAP_MY: begin
                ox = h_s - r_sy;
                oy = r_sx;
            end
            default: begin
                ox = r_sx;
                oy = r_sy;
            end
        endcase
    end

    assign reject = r_err || (r_pavg < SUM_W'(i_cfg.threshold));

    assign o_sts.last     = (r_cnt == CNT_W'(SAMPLES_PER_GROUP - 1));
    assign o_sts.reject   = reject;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_touched   = r_touched;
    assign o_screen_x  = r_screen_x;
    assign o_screen_y  = r_screen_y;

    // Group state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_psum      <= '0;
            r_xsum      <= '0;
            r_ysum      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_ACC) begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_psum <= r_psum + SUM_W'(i_pressure_word[WORD_W-1:FRAME_SHIFT]);
                r_xsum <= r_xsum + SUM_W'(i_x_word[WORD_W-1:FRAME_SHIFT]);
                r_ysum <= r_ysum + SUM_W'(i_y_word[WORD_W-1:FRAME_SHIFT]);
                r_err  <= r_err | i_bus_error;
            end else if (i_cmd.op == OP_LOAD_OUT) begin
                r_cnt  <= '0;
                r_psum <= '0;
                r_xsum <= '0;
                r_ysum <= '0;
                r_err  <= 1'b0;
            end
            if (i_cmd.op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP_AVG: begin
                case (i_cmd.sel)
                    SEL_P:   r_pavg <= div_quo[SUM_W-1:0];
                    SEL_X:   r_xavg <= div_quo[SUM_W-1:0];
                    default: r_yavg <= div_quo[SUM_W-1:0];
                endcase
            end
            OP_DIFF: begin
                r_neg <= diff[DIFF_W-1];
                r_mag <= diff_abs[MAG_W-1:0];
            end
            OP_MUL_STR: begin
                r_prod1 <= PROD1_W'(r_mag) * PROD1_W'(str_sel);
            end
            OP_MUL_SIZE: begin
                r_prod <= PROD_W'(r_prod1) * PROD_W'(size_sel);
            end
            OP_CAP_SCL: begin
                if (i_cmd.sel == SEL_X) begin
                    r_sx <= r_neg ? -scl_mag : scl_mag;
                end else begin
                    r_sy <= r_neg ? -scl_mag : scl_mag;
                end
            end
            OP_LOAD_OUT: begin
                r_touched  <= !reject;
                r_screen_x <= reject ? '0 : sat16(ox);
                r_screen_y <= reject ? '0 : sat16(oy);
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/tsac_ctrl.sv
// Controller: sequences accumulation, averaging, scaling and result loading.
module tsac_ctrl import tsac_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    t_sel   r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_P;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACC;
                    if (i_sts.last) begin
                        n_sel   = SEL_P;
                        n_state = ST_AVG_GO;
                    end
                end
            end
            ST_AVG_GO: begin
                o_cmd.op = OP_DIV_AVG;
                n_state  = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_CAP_AVG;
                    case (r_sel)
                        SEL_P: begin
                            n_sel   = SEL_X;
                            n_state = ST_AVG_GO;
                        end
                        SEL_X: begin
                            n_sel   = SEL_Y;
                            n_state = ST_AVG_GO;
                        end
                        default: n_state = ST_CHECK;
                    endcase
                end
            end
            ST_CHECK: begin
                n_sel = SEL_X;
                if (i_sts.reject) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_MUL_STR;
            end
            ST_MUL_STR: begin
                o_cmd.op = OP_MUL_STR;
                n_state  = ST_MUL_SIZE;
            end
            ST_MUL_SIZE: begin
                o_cmd.op = OP_MUL_SIZE;
                n_state  = ST_SCL_GO;
            end
            ST_SCL_GO: begin
                o_cmd.op = OP_DIV_SCL;
                n_state  = ST_SCL_WAIT;
            end
            ST_SCL_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_CAP_SCL;
                    if (r_sel == SEL_X) begin
                        n_sel   = SEL_Y;
                        n_state = ST_DIFF;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: tb/touch_sample_average_calibrate_top_tb.sv
// Self-checking testbench for the touch sample averaging and calibration block.
`timescale 1ns / 1ps

module touch_sample_average_calibrate_top_tb;
    import tsac_pkg::*;

    // One touch-controller sample as it is put on the sample channel.
    typedef struct {
        logic [WORD_W-1:0] pressure;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic              bus_error;
    } t_sample;

    // One calibrated touch report as it should leave the result channel.
    typedef struct {
        logic                    touched;
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
    } t_touch;

    // The result channel's ready follows runs of one of these kinds.
    typedef enum {
        RX_OPEN,
        RX_STALL,
        RX_JITTER
    } t_rx_mode;

    localparam int GROUP_LEN      = SAMPLES_PER_GROUP_DEF;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_PHASES  = 14;
    localparam int GROUPS_PER_PHASE = 9;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tsac_smp_if smp();
    tsac_res_if res();

    touch_sample_average_calibrate_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Samples waiting to be driven, and the touch reports the calibration model
    // expects, oldest first.
    t_sample sample_queue[$];
    t_touch  expected_touches[$];
    int      mismatch_count = 0;

    // The model's own copy of the calibration registers and of the group
    // accumulator. The registers only change while the block is idle, so the copy
    // is updated as soon as a write has gone through.
    t_cfg             cal;
    logic [CNT_W-1:0] grp_count;
    logic [SUM_W-1:0] grp_p_sum;
    logic [SUM_W-1:0] grp_x_sum;
    logic [SUM_W-1:0] grp_y_sum;
    logic             grp_err;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offset correction and scaling of one axis. The product of stretch, offset
    // distance and screen size is divided by the Q2.14 unit times the raw full
    // scale, on the magnitude, so that the quotient is truncated toward zero.
    function automatic longint scaled_offset(input int unsigned avg, input int unsigned ofs,
                                             input int unsigned gain, input int unsigned size);
        longint delta;
        longint mag;
        longint quot;
        delta = longint'(avg) - longint'(ofs);
        mag   = (delta < 0) ? -delta : delta;
        quot  = (mag * longint'(gain) * longint'(size))
                / (longint'(1 << Q14_SHIFT) * longint'(RAW_FULL_SCALE_DEF));
        return (delta < 0) ? -quot : quot;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return OUT_W'(32767);
        if (v < -32768)
            return OUT_W'(-32768);
        return OUT_W'(v);
    endfunction

    // Adds one sample to the running group. Returns 1, with the touch report in
    // rpt, when the sample closes the group.
    function automatic bit absorb_sample(input t_sample s, output t_touch rpt);
        int unsigned p_avg;
        int unsigned x_avg;
        int unsigned y_avg;
        longint      sx;
        longint      sy;
        longint      ox;
        longint      oy;
        rpt = '{touched: 1'b0, screen_x: '0, screen_y: '0};
        grp_p_sum = grp_p_sum + SUM_W'(s.pressure >> FRAME_SHIFT);
        grp_x_sum = grp_x_sum + SUM_W'(s.x >> FRAME_SHIFT);
        grp_y_sum = grp_y_sum + SUM_W'(s.y >> FRAME_SHIFT);
        grp_err   = grp_err | s.bus_error;
        grp_count = grp_count + CNT_W'(1);
        if (grp_count < GROUP_LEN)
            return 1'b0;

        p_avg = grp_p_sum / GROUP_LEN;
        x_avg = grp_x_sum / GROUP_LEN;
        y_avg = grp_y_sum / GROUP_LEN;

        // A bus error anywhere in the group or a light press reports not touched,
        // with both coordinates at zero.
        if (!grp_err && p_avg >= cal.threshold) begin
            sx = scaled_offset(x_avg, cal.offset_x, cal.stretch_x, cal.screen_width);
            sy = scaled_offset(y_avg, cal.offset_y, cal.stretch_y, cal.screen_height);
            case (cal.orientation)
                ORIENT_MIRROR: begin
                    ox = longint'(cal.screen_width) - sx;
                    oy = longint'(cal.screen_height) - sy;
                end
                ORIENT_SWAP_MX: begin
                    ox = sy;
                    oy = longint'(cal.screen_width) - sx;
                end
                ORIENT_SWAP_MY: begin
                    ox = longint'(cal.screen_height) - sy;
                    oy = sx;
                end
                default: begin
                    ox = sx;
                    oy = sy;
                end
            endcase
            rpt.touched  = 1'b1;
            rpt.screen_x = clamp16(ox);
            rpt.screen_y = clamp16(oy);
        end

        grp_count = '0;
        grp_p_sum = '0;
        grp_x_sum = '0;
        grp_y_sum = '0;
        grp_err   = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver. Beats go out in bursts of random length with random gaps in
    // between; a gap of zero joins two bursts into one long stretch. A beat stays
    // on the channel until the block takes it.
    // ------------------------------------------------------------------------
    logic    smp_taken = 1'b0;
    int      burst_left = 1;
    int      gap_left = 0;
    t_sample next_sample;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else if (!smp.valid || smp_taken) begin
            if (gap_left != 0) begin
                gap_left  <= gap_left - 1;
                smp.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                next_sample = sample_queue.pop_front();
                smp.pressure_word <= next_sample.pressure;
                smp.x_word        <= next_sample.x;
                smp.y_word        <= next_sample.y;
                smp.bus_error     <= next_sample.bus_error;
                smp.valid         <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Ready runs in stretches: wide open, fully stalled, or
    // toggling at random, so that the stalls land before, during and after the
    // block's long calculation at the end of a group.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       rx_mode = RX_STALL;
                    1:       rx_mode = RX_JITTER;
                    default: rx_mode = RX_OPEN;
                endcase
                rx_left = $urandom_range(1, 40);
            end
            rx_left = rx_left - 1;
            case (rx_mode)
                RX_STALL:  res.ready <= 1'b0;
                RX_JITTER: res.ready <= $urandom_range(0, 1);
                default:   res.ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge. A result beat is
    // checked against the oldest expected touch report before the sample beat of
    // the same edge is fed to the model; a group's result can never come out on
    // the edge that takes its last sample, so the order is safe.
    // ------------------------------------------------------------------------
    t_touch  due_touch;
    t_touch  new_touch;
    t_sample seen_sample;

    always @(posedge i_clk) begin
        smp_taken <= smp.valid && smp.ready;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (expected_touches.size() == 0) begin
                    report_mismatch("result beat with no sample group closed");
                end else begin
                    due_touch = expected_touches.pop_front();
                    if (res.touched !== due_touch.touched)
                        report_mismatch($sformatf("touched got %0b want %0b",
                                                  res.touched, due_touch.touched));
                    if (res.screen_x !== due_touch.screen_x)
                        report_mismatch($sformatf("screen_x got %0d want %0d",
                                                  res.screen_x, due_touch.screen_x));
                    if (res.screen_y !== due_touch.screen_y)
                        report_mismatch($sformatf("screen_y got %0d want %0d",
                                                  res.screen_y, due_touch.screen_y));
                end
            end
            if (smp.valid && smp.ready) begin
                seen_sample = '{pressure: smp.pressure_word, x: smp.x_word,
                                y: smp.y_word, bus_error: smp.bus_error};
                if (absorb_sample(seen_sample, new_touch))
                    expected_touches.push_back(new_touch);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // One APB write: setup cycle, then access cycle until pready. The model's
    // copy of the register takes the value masked to the register's width.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_THRESH:    cal.threshold     = value[THR_W-1:0];
            REG_WIDTH:     cal.screen_width  = value[SIZE_W-1:0];
            REG_HEIGHT:    cal.screen_height = value[SIZE_W-1:0];
            REG_OFFSET_X:  cal.offset_x      = value[OFS_W-1:0];
            REG_OFFSET_Y:  cal.offset_y      = value[OFS_W-1:0];
            REG_STRETCH_X: cal.stretch_x     = value[STR_W-1:0];
            REG_STRETCH_Y: cal.stretch_y     = value[STR_W-1:0];
            default:       cal.orientation   = t_orient'(value[ORI_W-1:0]);
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_sample(input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] x,
                               input logic [WORD_W-1:0] y, input logic err);
        sample_queue.push_back('{pressure: p, x: x, y: y, bus_error: err});
    endtask

    // Holds the sender back until every queued sample has been taken and every
    // expected report has come out, then lets the block settle. Registers are
    // only rewritten after this.
    task automatic drain();
        while (sample_queue.size() != 0 || smp.valid)
            @(posedge i_clk);
        while (expected_touches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register values lean toward zero and all ones of the field; now and then
    // the whole bus word is random so that the upper bits must be dropped.
    function automatic logic [DATA_W-1:0] random_reg_value(input int w);
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2, 3:    return DATA_W'((1 << w) - 1);
            4:       return $urandom;
            default: return DATA_W'($urandom_range(0, (1 << w) - 1));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, a short directed part, then random phases, each with
    // a fresh register setting and a whole number of groups.
    // ------------------------------------------------------------------------
    initial begin
        logic [WORD_W-1:0] corner_words[8];
        logic [DATA_W-1:0] orient_value;
        int                ph;
        int                grp;
        int                k;

        corner_words = '{16'h0000, 16'hFFFF, 16'h0007, 16'hFFF8,
                         16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF};

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        smp.valid         = 1'b0;
        smp.pressure_word = '0;
        smp.x_word        = '0;
        smp.y_word        = '0;
        smp.bus_error     = 1'b0;
        res.ready         = 1'b0;

        cal = '{threshold: THR_RST, screen_width: WIDTH_RST, screen_height: HEIGHT_RST,
                offset_x: OFS_RST, offset_y: OFS_RST, stretch_x: STR_RST,
                stretch_y: STR_RST, orientation: ORIENT_NONE};
        grp_count = '0;
        grp_p_sum = '0;
        grp_x_sum = '0;
        grp_y_sum = '0;
        grp_err   = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one group whose frame words run through the corner
        // patterns, including the three low bits that the frame shift drops.
        for (k = 0; k < GROUP_LEN; k++)
            push_sample(corner_words[k], corner_words[(k + 3) % 8],
                        corner_words[(k + 5) % 8], 1'b0);
        drain();

        // Every register at its top value with mirroring. Raw x and y far below
        // the offsets give a large negative position, and mirroring it pushes the
        // result past the positive limit, so both coordinates saturate. The
        // pressure average sits exactly on the top threshold.
        write_reg(REG_THRESH, DATA_W'(8191));
        write_reg(REG_WIDTH, DATA_W'(4095));
        write_reg(REG_HEIGHT, DATA_W'(4095));
        write_reg(REG_OFFSET_X, DATA_W'(8191));
        write_reg(REG_OFFSET_Y, DATA_W'(8191));
        write_reg(REG_STRETCH_X, DATA_W'(65535));
        write_reg(REG_STRETCH_Y, DATA_W'(65535));
        write_reg(REG_ORIENT, DATA_W'(ORIENT_MIRROR));
        for (k = 0; k < GROUP_LEN; k++)
            push_sample(16'hFFFF, 16'h0000, 16'h0007, 1'b0);

        // Same setting, but one sample of the group failed on the bus: its values
        // still enter the sums, and the whole group reports not touched.
        for (k = 0; k < GROUP_LEN; k++)
            push_sample(16'hFFFF, 16'h0000, 16'h0007, k == 5);
        drain();

        // Random phases. The orientation steps through all four settings, and a
        // fresh random setting of the other registers comes with each phase.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(REG_THRESH, random_reg_value(THR_W));
            write_reg(REG_WIDTH, random_reg_value(SIZE_W));
            write_reg(REG_HEIGHT, random_reg_value(SIZE_W));
            write_reg(REG_OFFSET_X, random_reg_value(OFS_W));
            write_reg(REG_OFFSET_Y, random_reg_value(OFS_W));
            write_reg(REG_STRETCH_X, random_reg_value(STR_W));
            write_reg(REG_STRETCH_Y, random_reg_value(STR_W));
            orient_value = DATA_W'(ph % 4);
            if ($urandom_range(0, 3) == 0)
                orient_value = orient_value | ($urandom & ~DATA_W'(3));
            write_reg(REG_ORIENT, orient_value);

            for (grp = 0; grp < GROUPS_PER_PHASE; grp++)
                for (k = 0; k < GROUP_LEN; k++)
                    push_sample(random_word(), random_word(), random_word(),
                                $urandom_range(0, 31) == 0);

            // The sender waits here until every report of the phase is out.
            drain();
        end

        if (mismatch_count == 0) begin
            $display("touch_sample_average_calibrate_top regression: pass");
        end else begin
            $display("touch_sample_average_calibrate_top regression: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under half a millisecond.
    initial begin
        #4_000_000;
        $display("touch_sample_average_calibrate_top regression: fail");
        $finish;
    end

endmodule
